// ----- sv/assembly_text_tokenizer_top_defines.svh -----
// assertion macros for the assembly text tokenizer checker
// expects clk and rst to be visible where a macro is used
`ifndef ASSEMBLY_TEXT_TOKENIZER_TOP_DEFINES_SVH
`define ASSEMBLY_TEXT_TOKENIZER_TOP_DEFINES_SVH

// property checked while out of reset
`define ATT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every edge, reset included
`define ATT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/att_pkg.sv -----
// shared types, codes and the byte classifier of the assembly text tokenizer
// no dependencies
`default_nettype none

package att_pkg;

  localparam logic [2:0] KIND_END     = 3'd0;
  localparam logic [2:0] KIND_DOT     = 3'd1;
  localparam logic [2:0] KIND_DASH    = 3'd2;
  localparam logic [2:0] KIND_COMMENT = 3'd3;
  localparam logic [2:0] KIND_SPACE   = 3'd4;
  localparam logic [2:0] KIND_SYMBOL  = 3'd5;
  localparam logic [2:0] KIND_CHAR    = 3'd6;
  localparam logic [2:0] KIND_NUMBER  = 3'd7;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_ESCAPE  = 2'd1;
  localparam logic [1:0] ERR_LITSIZE = 2'd2;
  localparam logic [1:0] ERR_CHAR    = 2'd3;

  localparam logic REG_MASK_LOW  = 1'b0;
  localparam logic REG_MASK_HIGH = 1'b1;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_V     = 8'h76;

  typedef struct packed {
    logic sp;
    logic dg;
    logic sy;
  } class_t;

  typedef struct packed {
    logic [7:0] text;
    logic       fin;
    class_t     cls;
  } item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  cbyte;
    logic        valid;
    logic        first;
    logic        last;
    logic [15:0] line;
    logic [15:0] col;
    logic [1:0]  err;
    logic        done;
  } res_t;

  function automatic class_t char_class(logic [7:0] b, logic [63:0] lo, logic [63:0] hi);
    class_t c;
    c.sp = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    c.dg = (b >= CH_ZERO) && (b <= CH_NINE);
    if (b[7]) c.sy = 1'b0;
    else if (b[6]) c.sy = hi[b[5:0]];
    else c.sy = lo[b[5:0]];
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- sv/att_fifo.sv -----
// small first-word-fall-through queue in registers
// depth must be a power of two; no package dependency
`default_nettype none

module att_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         wr_en,
  input  wire logic [W-1:0] wr_data,
  output logic              full,
  input  wire logic         rd_en,
  output logic [W-1:0]      rd_data,
  output logic              empty
);

  localparam int AW = $clog2(DEPTH);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wp;
  logic [AW-1:0] rp;
  logic [AW:0]   cnt;
  logic          do_wr;
  logic          do_rd;

  assign full    = (cnt == (AW+1)'(DEPTH));
  assign empty   = (cnt == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (do_wr) mem[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_wr) wp <= wp + AW'(1);
      if (do_rd) rp <= rp + AW'(1);
      if (do_wr && !do_rd) cnt <= cnt + (AW+1)'(1);
      else if (do_rd && !do_wr) cnt <= cnt - (AW+1)'(1);
    end
  end

endmodule

`default_nettype wire

// ----- sv/att_front.sv -----
// front part: takes bytes, classifies them and queues them for the lexer
// depends on att_pkg and att_fifo
`default_nettype none

module att_front (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  output logic              full,
  input  wire logic [7:0]   text_byte,
  input  wire logic         final_byte,
  input  wire logic [63:0]  mask_low,
  input  wire logic [63:0]  mask_high,
  output att_pkg::item_t    item,
  output logic              item_empty,
  input  wire logic         item_pop
);

  att_pkg::item_t in_item;

  always_comb begin
    in_item.text = text_byte;
    in_item.fin  = final_byte;
    in_item.cls  = att_pkg::char_class(text_byte, mask_low, mask_high);
  end

  att_fifo #(
    .W     ($bits(att_pkg::item_t)),
    .DEPTH (4)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (in_item),
    .full    (full),
    .rd_en   (item_pop),
    .rd_data (item),
    .empty   (item_empty)
  );

endmodule

`default_nettype wire

// ----- sv/att_lexer.sv -----
// back part: lexer state, one step per byte, results drained from a burst buffer
// depends on att_pkg
`default_nettype none

module att_lexer #(
  parameter int POSITION_BITS = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [63:0]    mask_low,
  input  wire logic [63:0]    mask_high,
  input  wire att_pkg::item_t item,
  input  wire logic           item_empty,
  output logic                item_pop,
  output att_pkg::res_t       res,
  output logic                res_push,
  input  wire logic           res_full
);

  localparam int P = POSITION_BITS;

  typedef enum logic [10:0] {
    M_IDLE      = 11'b00000000001,
    M_WS        = 11'b00000000010,
    M_CMT_EMPTY = 11'b00000000100,
    M_CMT_FIRST = 11'b00000001000,
    M_CMT_REST  = 11'b00000010000,
    M_SYM_FIRST = 11'b00000100000,
    M_SYM_REST  = 11'b00001000000,
    M_NUM_FIRST = 11'b00010000000,
    M_NUM_REST  = 11'b00100000000,
    M_DASH      = 11'b01000000000,
    M_LIT       = 11'b10000000000
  } mode_t;

  typedef logic [P-1:0] pos_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] la0;
    logic [7:0] la1;
    logic [7:0] la2;
    logic [1:0] lac;
    pos_t       cl;
    pos_t       cc;
    pos_t       tl;
    pos_t       tc;
    logic       pt;
    logic       hl;
  } st_t;

  typedef struct packed {
    st_t                      s;
    logic [2:0]               n;
    att_pkg::res_t [5:0]      r;
  } ctx_t;

  function automatic pos_t sat_inc(pos_t v);
    return (v == {P{1'b1}}) ? v : v + pos_t'(1);
  endfunction

  function automatic logic [15:0] p16(pos_t v);
    logic [31:0] w;
    w = 32'(v);
    return w[15:0];
  endfunction

  function automatic ctx_t emit(ctx_t c, logic [2:0] k, logic [7:0] b, logic v, logic f,
                                logic l, pos_t ln, pos_t co, logic [1:0] e, logic d);
    att_pkg::res_t r;
    r.kind  = k;
    r.cbyte = b;
    r.valid = v;
    r.first = f;
    r.last  = l;
    r.line  = p16(ln);
    r.col   = p16(co);
    r.err   = e;
    r.done  = d;
    if (c.n < 3'd6) begin
      c.r[c.n] = r;
      c.n = c.n + 3'd1;
    end
    return c;
  endfunction

  function automatic ctx_t emit_tok(ctx_t c, logic [2:0] k, logic [7:0] b, logic v,
                                    logic f, logic l);
    return emit(c, k, b, v, f, l, c.s.tl, c.s.tc, att_pkg::ERR_NONE, 1'b0);
  endfunction

  function automatic ctx_t adv(ctx_t c, logic nl);
    if (nl) begin
      c.s.cl = sat_inc(c.s.cl);
      c.s.cc = '0;
    end else begin
      c.s.cc = sat_inc(c.s.cc);
    end
    return c;
  endfunction

  function automatic ctx_t fail(ctx_t c, logic [1:0] code, pos_t co);
    c = emit(c, att_pkg::KIND_END, 8'd0, 1'b0, 1'b0, 1'b0, c.s.tl, co, code, 1'b1);
    c.s.hl = 1'b1;
    return c;
  endfunction

  function automatic ctx_t close_run(ctx_t c, logic [2:0] k);
    logic f;
    f = (c.s.mode == M_CMT_FIRST) || (c.s.mode == M_SYM_FIRST) || (c.s.mode == M_NUM_FIRST);
    if (c.s.mode == M_CMT_EMPTY)
      c = emit_tok(c, att_pkg::KIND_COMMENT, 8'd0, 1'b0, 1'b1, 1'b1);
    else
      c = emit_tok(c, k, c.s.la0, 1'b1, f, 1'b1);
    c.s.mode = M_IDLE;
    return c;
  endfunction

  function automatic ctx_t extend_run(ctx_t c, logic [2:0] k, logic [7:0] b, logic f,
                                      mode_t nxt);
    c = emit_tok(c, k, c.s.la0, 1'b1, f, 1'b0);
    c.s.la0  = b;
    c.s.mode = nxt;
    c = adv(c, 1'b0);
    return c;
  endfunction

  function automatic ctx_t start(ctx_t c, logic [7:0] b, att_pkg::class_t cls);
    c.s.tl = c.s.cl;
    c.s.tc = c.s.cc;
    if (b == att_pkg::CH_NUL) begin
      c = emit_tok(c, att_pkg::KIND_END, 8'd0, 1'b1, 1'b1, 1'b1);
      c = adv(c, 1'b0);
      c.s.mode = M_IDLE;
    end else if (b == att_pkg::CH_DOT) begin
      c = emit_tok(c, att_pkg::KIND_DOT, b, 1'b1, 1'b1, 1'b1);
      c = adv(c, 1'b0);
      c.s.mode = M_IDLE;
    end else if (b == att_pkg::CH_HASH) begin
      c = adv(c, 1'b0);
      c.s.mode = M_CMT_EMPTY;
    end else if (b == att_pkg::CH_QUOTE) begin
      c.s.lac  = 2'd0;
      c.s.mode = M_LIT;
    end else if (cls.sp) begin
      c = emit_tok(c, att_pkg::KIND_SPACE, 8'd0, 1'b0, 1'b1, 1'b1);
      c = adv(c, b == att_pkg::CH_NL);
      c.s.mode = M_WS;
    end else if (b == att_pkg::CH_DASH) begin
      c.s.la0  = b;
      c.s.mode = M_DASH;
    end else if (cls.dg) begin
      c.s.pt   = 1'b0;
      c.s.la0  = b;
      c.s.mode = M_NUM_FIRST;
      c = adv(c, 1'b0);
    end else if (cls.sy) begin
      c.s.la0  = b;
      c.s.mode = M_SYM_FIRST;
      c = adv(c, 1'b0);
    end else begin
      c = fail(c, att_pkg::ERR_CHAR, c.s.tc);
    end
    return c;
  endfunction

  function automatic ctx_t lit_res(ctx_t c, logic fin, logic [63:0] lo, logic [63:0] hi);
    logic [1:0] n;
    logic [7:0] c0;
    pos_t       col1;
    logic [7:0] e;
    logic       bad;
    n    = c.s.lac;
    c0   = (n != 2'd0) ? c.s.la0 : 8'd0;
    col1 = sat_inc(c.s.tc);
    e    = 8'd0;
    bad  = 1'b0;
    if (!fin) begin
      if (n == 2'd0) return c;
      if ((c0 == att_pkg::CH_BSL) ? (n < 2'd3) : (n < 2'd2)) return c;
    end
    if (c0 == att_pkg::CH_BSL && n == 2'd3 && c.s.la2 == att_pkg::CH_QUOTE) begin
      case (c.s.la1)
        att_pkg::CH_N: e = att_pkg::CH_NL;
        att_pkg::CH_T: e = att_pkg::CH_TAB;
        att_pkg::CH_R: e = att_pkg::CH_CR;
        att_pkg::CH_V: e = att_pkg::CH_VT;
        att_pkg::CH_F: e = att_pkg::CH_FF;
        default:       bad = 1'b1;
      endcase
      if (bad) return fail(c, att_pkg::ERR_ESCAPE, col1);
      c = emit(c, att_pkg::KIND_CHAR, e, 1'b1, 1'b1, 1'b1, c.s.tl, col1,
               att_pkg::ERR_NONE, 1'b0);
      c = adv(c, 1'b0);
      c = adv(c, 1'b0);
      c = adv(c, 1'b0);
      c = adv(c, 1'b0);
      c.s.lac  = 2'd0;
      c.s.mode = M_IDLE;
      return c;
    end
    if (!(n > 2'd1 && c.s.la1 == att_pkg::CH_QUOTE))
      return fail(c, att_pkg::ERR_LITSIZE, col1);
    c = emit(c, att_pkg::KIND_CHAR, c0, 1'b1, 1'b1, 1'b1, c.s.tl, col1,
             att_pkg::ERR_NONE, 1'b0);
    c = adv(c, 1'b0);
    c = adv(c, 1'b0);
    c = adv(c, 1'b0);
    c.s.lac  = 2'd0;
    c.s.mode = M_IDLE;
    if (n == 2'd3) c = start(c, c.s.la2, att_pkg::char_class(c.s.la2, lo, hi));
    return c;
  endfunction

  function automatic ctx_t feed(ctx_t c, logic [7:0] b, att_pkg::class_t cls,
                                logic [63:0] lo, logic [63:0] hi);
    att_pkg::class_t dc;
    dc = att_pkg::char_class(att_pkg::CH_DASH, lo, hi);
    case (c.s.mode)
      M_WS: begin
        if (cls.sp) c = adv(c, b == att_pkg::CH_NL);
        else begin
          c.s.mode = M_IDLE;
          c = start(c, b, cls);
        end
      end
      M_CMT_EMPTY, M_CMT_FIRST, M_CMT_REST: begin
        if (b == att_pkg::CH_NL || b == att_pkg::CH_NUL) begin
          c = close_run(c, att_pkg::KIND_COMMENT);
          c = start(c, b, cls);
        end else if (c.s.mode == M_CMT_EMPTY) begin
          c.s.la0  = b;
          c.s.mode = M_CMT_FIRST;
          c = adv(c, 1'b0);
        end else begin
          c = extend_run(c, att_pkg::KIND_COMMENT, b, c.s.mode == M_CMT_FIRST, M_CMT_REST);
        end
      end
      M_SYM_FIRST, M_SYM_REST: begin
        if (cls.sy)
          c = extend_run(c, att_pkg::KIND_SYMBOL, b, c.s.mode == M_SYM_FIRST, M_SYM_REST);
        else begin
          c = close_run(c, att_pkg::KIND_SYMBOL);
          c = start(c, b, cls);
        end
      end
      M_NUM_FIRST, M_NUM_REST: begin
        if (cls.dg || (b == att_pkg::CH_DOT && !c.s.pt)) begin
          if (b == att_pkg::CH_DOT) c.s.pt = 1'b1;
          c = extend_run(c, att_pkg::KIND_NUMBER, b, c.s.mode == M_NUM_FIRST, M_NUM_REST);
        end else begin
          c = close_run(c, att_pkg::KIND_NUMBER);
          c = start(c, b, cls);
        end
      end
      M_DASH: begin
        if (cls.sp || b == att_pkg::CH_NUL) begin
          c = emit_tok(c, att_pkg::KIND_DASH, att_pkg::CH_DASH, 1'b1, 1'b1, 1'b1);
          c = adv(c, 1'b0);
          c.s.mode = M_IDLE;
          c = start(c, b, cls);
        end else if (cls.dg) begin
          c = adv(c, 1'b0);
          c.s.pt = 1'b0;
          c = extend_run(c, att_pkg::KIND_NUMBER, b, 1'b1, M_NUM_REST);
        end else if (dc.sy) begin
          // dash becomes the first symbol byte
          c = adv(c, 1'b0);
          c.s.mode = M_SYM_FIRST;
          if (cls.sy) c = extend_run(c, att_pkg::KIND_SYMBOL, b, 1'b1, M_SYM_REST);
          else begin
            c = close_run(c, att_pkg::KIND_SYMBOL);
            c = start(c, b, cls);
          end
        end else begin
          c = fail(c, att_pkg::ERR_CHAR, c.s.tc);
        end
      end
      M_LIT: begin
        if (c.s.lac != 2'd3) begin
          case (c.s.lac)
            2'd0:    c.s.la0 = b;
            2'd1:    c.s.la1 = b;
            default: c.s.la2 = b;
          endcase
          c.s.lac = c.s.lac + 2'd1;
        end
        c = lit_res(c, 1'b0, lo, hi);
      end
      default: begin
        c.s.mode = M_IDLE;
        c = start(c, b, cls);
      end
    endcase
    return c;
  endfunction

  function automatic ctx_t flush(ctx_t c, logic [63:0] lo, logic [63:0] hi);
    case (c.s.mode)
      M_CMT_EMPTY, M_CMT_FIRST, M_CMT_REST: c = close_run(c, att_pkg::KIND_COMMENT);
      M_SYM_FIRST, M_SYM_REST:              c = close_run(c, att_pkg::KIND_SYMBOL);
      M_NUM_FIRST, M_NUM_REST:              c = close_run(c, att_pkg::KIND_NUMBER);
      M_DASH: begin
        c = emit_tok(c, att_pkg::KIND_DASH, att_pkg::CH_DASH, 1'b1, 1'b1, 1'b1);
        c = adv(c, 1'b0);
        c.s.mode = M_IDLE;
      end
      M_LIT:   c = lit_res(c, 1'b1, lo, hi);
      default: c.s.mode = M_IDLE;
    endcase
    return c;
  endfunction

  function automatic st_t clear_scan(st_t s);
    s.mode = M_IDLE;
    s.la0  = 8'd0;
    s.la1  = 8'd0;
    s.la2  = 8'd0;
    s.lac  = 2'd0;
    s.cl   = pos_t'(1);
    s.cc   = '0;
    s.tl   = pos_t'(1);
    s.tc   = '0;
    s.pt   = 1'b0;
    return s;
  endfunction

  st_t                 st;
  att_pkg::res_t [5:0] bq;
  logic [2:0]          bn;
  logic [2:0]          bi;
  ctx_t                cx;
  logic                busy;
  logic                take;

  always_comb begin
    cx.s = st;
    cx.n = 3'd0;
    cx.r = '0;
    if (!st.hl) begin
      cx = feed(cx, item.text, item.cls, mask_low, mask_high);
      if (!cx.s.hl && item.fin) begin
        cx = flush(cx, mask_low, mask_high);
        if (!cx.s.hl) begin
          if (cx.n == 3'd0)
            cx = emit(cx, att_pkg::KIND_END, 8'd0, 1'b0, 1'b0, 1'b0, cx.s.cl, cx.s.cc,
                      att_pkg::ERR_NONE, 1'b1);
          else
            cx.r[cx.n - 3'd1].done = 1'b1;
          cx.s = clear_scan(cx.s);
        end
      end
    end
  end

  assign busy     = (bi != bn);
  assign res_push = busy && !res_full;
  assign res      = bq[bi];
  assign take     = !item_empty && (!busy || (res_push && (bi + 3'd1 == bn)));
  assign item_pop = take;

  always_ff @(posedge clk) begin
    if (take) bq <= cx.r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      // halted flag clears with the rest of the zeroed state
      st    <= clear_scan(st_t'('0));
      bn    <= 3'd0;
      bi    <= 3'd0;
    end else if (take) begin
      st <= cx.s;
      bn <= cx.n;
      bi <= 3'd0;
    end else if (res_push) begin
      bi <= bi + 3'd1;
    end
  end

endmodule

`default_nettype wire

// ----- sv/assembly_text_tokenizer_top.sv -----
// top level of the assembly text tokenizer: config registers, front, lexer, result queue
// depends on att_pkg, att_front, att_lexer and att_fifo
`default_nettype none

// Source text goes in one byte per push; results come out of a queue, one
// content byte per result with its token kind and start position. The
// results of a byte leave the lexer's burst buffer one at a time, whenever
// the result queue has room, through its single write port, and the lexer
// takes the next byte once the buffer is empty or its last result goes out.
// A 4-entry input queue and a 4-entry result queue let both sides stall on
// their own. The two symbol mask registers are written through cfg_write;
// the user must do so only while the block is idle, as the block itself
// does not enforce it. After the first error the block swallows bytes until reset.
module assembly_text_tokenizer_top #(
  parameter int POSITION_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // byte input queue
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  text_byte,
  input  wire logic        final_byte,
  // result queue
  output logic             empty,
  input  wire logic        pop,
  output logic [2:0]       token_kind,
  output logic [7:0]       content_byte,
  output logic             content_valid,
  output logic             token_first,
  output logic             token_last,
  output logic [15:0]      start_line,
  output logic [15:0]      start_column,
  output logic [1:0]       error_code,
  output logic             input_done,
  // configuration
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [63:0] cfg_data
);

  // symbol mask registers
  logic [63:0] mask_low;
  logic [63:0] mask_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask_low  <= '0;
      mask_high <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        att_pkg::REG_MASK_LOW:  mask_low  <= cfg_data;
        att_pkg::REG_MASK_HIGH: mask_high <= cfg_data;
        default:                mask_low  <= mask_low;
      endcase
    end
  end

  // front: classify and queue bytes
  att_pkg::item_t item;
  logic           item_empty;
  logic           item_pop;

  att_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .text_byte  (text_byte),
    .final_byte (final_byte),
    .mask_low   (mask_low),
    .mask_high  (mask_high),
    .item       (item),
    .item_empty (item_empty),
    .item_pop   (item_pop)
  );

  // back: lexer with burst buffer
  att_pkg::res_t lex_res;
  logic          lex_push;
  logic          res_full;

  att_lexer #(
    .POSITION_BITS (POSITION_BITS)
  ) u_lexer (
    .clk        (clk),
    .rst        (rst),
    .mask_low   (mask_low),
    .mask_high  (mask_high),
    .item       (item),
    .item_empty (item_empty),
    .item_pop   (item_pop),
    .res        (lex_res),
    .res_push   (lex_push),
    .res_full   (res_full)
  );

  // result queue, oldest result shows on the ports
  att_pkg::res_t out_res;

  att_fifo #(
    .W     ($bits(att_pkg::res_t)),
    .DEPTH (4)
  ) u_out_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (lex_push),
    .wr_data (lex_res),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (out_res),
    .empty   (empty)
  );

  assign token_kind    = out_res.kind;
  assign content_byte  = out_res.cbyte;
  assign content_valid = out_res.valid;
  assign token_first   = out_res.first;
  assign token_last    = out_res.last;
  assign start_line    = out_res.line;
  assign start_column  = out_res.col;
  assign error_code    = out_res.err;
  assign input_done    = out_res.done;

endmodule

`default_nettype wire

// ----- sv/att_checker.sv -----
// port-level checks on the assembly text tokenizer, bound to the top level
// depends on assembly_text_tokenizer_top_defines.svh and att_pkg
`default_nettype none
`include "assembly_text_tokenizer_top_defines.svh"

module att_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [2:0]  token_kind,
  input wire logic [7:0]  content_byte,
  input wire logic        content_valid,
  input wire logic [1:0]  error_code,
  input wire logic        input_done
);

  // a waiting result holds until popped
  `ATT_ASSERT(a_hold, (!empty && !pop) |=> (!empty && $stable(content_byte) && $stable(token_kind)), "result changed while waiting")

  // an error result is an end-kind done marker
  `ATT_ASSERT(a_err_done, (!empty && error_code != att_pkg::ERR_NONE) |-> (input_done && token_kind == att_pkg::KIND_END && !content_valid), "malformed error result")

  // reset leaves no result waiting
  `ATT_ASSERT_ALWAYS(a_rst_empty, rst |=> empty, "result queue not empty after reset")

endmodule

bind assembly_text_tokenizer_top att_checker u_att_checker (.*);

`default_nettype wire

// ----- tb/sv/tb_assembly_text_tokenizer_top.sv -----
// self-checking testbench for assembly_text_tokenizer_top: byte stream in, token results out
// predicts every result with its own lexer model; needs att_pkg and the tokenizer rtl
`timescale 1ns / 1ps

module tb_assembly_text_tokenizer_top;
  import att_pkg::*;

  localparam int DRAIN_CYCLES = 24;   // lexer plus both queues, with margin
  localparam int STALL_LIMIT  = 3000; // cycles with no request moving
  localparam int HOLD_CYCLES  = 200;  // long receiver hold-off
  localparam int PHASE_BYTES  = 45;

  // lexer modes of the prediction model
  typedef enum logic [3:0] {
    LX_IDLE, LX_WS, LX_CMT_EMPTY, LX_CMT_FIRST, LX_CMT_REST, LX_SYM_FIRST,
    LX_SYM_REST, LX_NUM_FIRST, LX_NUM_REST, LX_DASH, LX_LIT
  } lex_mode_t;

  typedef struct {
    lex_mode_t       mode;
    logic [2:0][7:0] la;
    int              la_n;
    logic [15:0]     cur_line, cur_col, tok_line, tok_col;
    bit              point_seen, halted;
  } scan_t;

  typedef struct {
    logic [7:0] b;
    bit         f;
  } src_t;

  typedef struct {
    logic [7:0] b;
    bit         f;
    bit         typed;
    res_t       fixed;
  } drow_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  text_byte = '0;
  logic        final_byte = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  token_kind;
  logic [7:0]  content_byte;
  logic        content_valid;
  logic        token_first;
  logic        token_last;
  logic [15:0] start_line;
  logic [15:0] start_column;
  logic [1:0]  error_code;
  logic        input_done;
  logic        cfg_write = 1'b0;
  logic        cfg_index = REG_MASK_LOW;
  logic [63:0] cfg_data = '0;

  assembly_text_tokenizer_top dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .text_byte(text_byte), .final_byte(final_byte),
    .empty(empty), .pop(pop),
    .token_kind(token_kind), .content_byte(content_byte),
    .content_valid(content_valid), .token_first(token_first),
    .token_last(token_last), .start_line(start_line),
    .start_column(start_column), .error_code(error_code),
    .input_done(input_done),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // model state, symbol masks, and the results of the byte being predicted
  scan_t       sc;
  logic [63:0] mask_lo, mask_hi;
  res_t        burst[$];
  res_t        expected_tokens[$];

  int fail_count = 0;
  int send_idle = 0;   // percent of cycles the sender holds push low
  int recv_idle = 0;   // percent of cycles the receiver holds pop low
  bit hold_req = 0;    // asks the receiver for one long hold-off

  // ---------------------------------------------------------------------
  // token prediction
  // ---------------------------------------------------------------------
  function automatic logic [15:0] sat_inc(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic void advance(bit newline);
    if (newline) begin
      sc.cur_line = sat_inc(sc.cur_line);
      sc.cur_col  = '0;
    end else begin
      sc.cur_col = sat_inc(sc.cur_col);
    end
  endfunction

  function automatic bit is_space(logic [7:0] b);
    return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic bit is_digit(logic [7:0] b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  function automatic bit is_sym_byte(logic [7:0] b);
    if (b >= 8'd128) return 1'b0;
    if (b >= 8'd64) return mask_hi[b - 8'd64];
    return mask_lo[b];
  endfunction

  function automatic void push_result(logic [2:0] kind, logic [7:0] cb, bit v, bit f,
                                      bit l, logic [15:0] ln, logic [15:0] cl,
                                      logic [1:0] er, bit dn);
    res_t r;
    r.kind = kind; r.cbyte = cb; r.valid = v; r.first = f; r.last = l;
    r.line = ln; r.col = cl; r.err = er; r.done = dn;
    burst.push_back(r);
  endfunction

  function automatic void emit_token(logic [2:0] kind, logic [7:0] cb, bit v, bit f, bit l);
    push_result(kind, cb, v, f, l, sc.tok_line, sc.tok_col, ERR_NONE, 1'b0);
  endfunction

  function automatic void raise_error(logic [1:0] code, logic [15:0] col);
    push_result(KIND_END, 8'h00, 1'b0, 1'b0, 1'b0, sc.tok_line, col, code, 1'b1);
    sc.halted = 1'b1;
  endfunction

  function automatic void clear_scan();
    sc.mode = LX_IDLE;
    sc.la = '0;
    sc.la_n = 0;
    sc.cur_line = 16'd1; sc.cur_col = '0;
    sc.tok_line = 16'd1; sc.tok_col = '0;
    sc.point_seen = 1'b0;
  endfunction

  // first byte of a new token
  function automatic void start_token(logic [7:0] b);
    sc.tok_line = sc.cur_line;
    sc.tok_col  = sc.cur_col;
    if (b == CH_NUL) begin
      emit_token(KIND_END, 8'h00, 1, 1, 1); advance(0); sc.mode = LX_IDLE;
    end else if (b == CH_DOT) begin
      emit_token(KIND_DOT, b, 1, 1, 1); advance(0); sc.mode = LX_IDLE;
    end else if (b == CH_HASH) begin
      advance(0); sc.mode = LX_CMT_EMPTY;
    end else if (b == CH_QUOTE) begin
      sc.la_n = 0; sc.mode = LX_LIT;
    end else if (is_space(b)) begin
      emit_token(KIND_SPACE, 8'h00, 0, 1, 1); advance(b == CH_NL); sc.mode = LX_WS;
    end else if (b == CH_DASH) begin
      sc.la[0] = b; sc.mode = LX_DASH;
    end else if (is_digit(b)) begin
      sc.point_seen = 1'b0; sc.la[0] = b; sc.mode = LX_NUM_FIRST; advance(0);
    end else if (is_sym_byte(b)) begin
      sc.la[0] = b; sc.mode = LX_SYM_FIRST; advance(0);
    end else begin
      raise_error(ERR_CHAR, sc.tok_col);
    end
  endfunction

  // held byte leaves as the last result of its run, or an empty comment as one result with no content
  function automatic void close_run(logic [2:0] kind);
    if (sc.mode == LX_CMT_EMPTY)
      emit_token(KIND_COMMENT, 8'h00, 0, 1, 1);
    else
      emit_token(kind, sc.la[0], 1, sc.mode inside {LX_CMT_FIRST, LX_SYM_FIRST,
                 LX_NUM_FIRST}, 1);
    sc.mode = LX_IDLE;
  endfunction

  function automatic void extend_run(logic [2:0] kind, logic [7:0] b, bit f,
                                     lex_mode_t nxt);
    emit_token(kind, sc.la[0], 1, f, 0);
    sc.la[0] = b;
    sc.mode = nxt;
    advance(0);
  endfunction

  function automatic void resolve_literal(bit at_end);
    int          n;
    logic [7:0]  c0, esc;
    logic [15:0] col1;
    bit          known;
    n = sc.la_n;
    c0 = (n > 0) ? sc.la[0] : 8'h00;
    col1 = sat_inc(sc.tok_col);
    if (!at_end) begin
      if (n == 0) return;
      if ((c0 == CH_BSL) ? (n < 3) : (n < 2)) return;
    end
    if (n > 2 && c0 == CH_BSL && sc.la[2] == CH_QUOTE) begin
      known = 1'b1;
      case (sc.la[1])
        CH_N: esc = CH_NL;
        CH_T: esc = CH_TAB;
        CH_R: esc = CH_CR;
        CH_V: esc = CH_VT;
        CH_F: esc = CH_FF;
        default: begin
          known = 1'b0;
          esc = 8'h00;
        end
      endcase
      if (!known) begin
        raise_error(ERR_ESCAPE, col1);
        return;
      end
      push_result(KIND_CHAR, esc, 1, 1, 1, sc.tok_line, col1, ERR_NONE, 0);
      repeat (4) advance(0);
      sc.la_n = 0; sc.mode = LX_IDLE;
      return;
    end
    if (!(n > 1 && sc.la[1] == CH_QUOTE)) begin
      raise_error(ERR_LITSIZE, col1);
      return;
    end
    push_result(KIND_CHAR, c0, 1, 1, 1, sc.tok_line, col1, ERR_NONE, 0);
    repeat (3) advance(0);
    sc.la_n = 0; sc.mode = LX_IDLE;
    // third held byte starts the next token
    if (n == 3) start_token(sc.la[2]);
  endfunction

  function automatic void feed_byte(logic [7:0] b);
    case (sc.mode)
      LX_WS: begin
        if (is_space(b)) advance(b == CH_NL);
        else begin
          sc.mode = LX_IDLE; start_token(b);
        end
      end
      LX_CMT_EMPTY, LX_CMT_FIRST, LX_CMT_REST: begin
        if (b == CH_NL || b == CH_NUL) begin
          close_run(KIND_COMMENT); start_token(b);
        end else if (sc.mode == LX_CMT_EMPTY) begin
          sc.la[0] = b; sc.mode = LX_CMT_FIRST; advance(0);
        end else begin
          extend_run(KIND_COMMENT, b, sc.mode == LX_CMT_FIRST, LX_CMT_REST);
        end
      end
      LX_SYM_FIRST, LX_SYM_REST: begin
        if (is_sym_byte(b)) extend_run(KIND_SYMBOL, b, sc.mode == LX_SYM_FIRST, LX_SYM_REST);
        else begin
          close_run(KIND_SYMBOL); start_token(b);
        end
      end
      LX_NUM_FIRST, LX_NUM_REST: begin
        if (is_digit(b) || (b == CH_DOT && !sc.point_seen)) begin
          if (b == CH_DOT) sc.point_seen = 1'b1;
          extend_run(KIND_NUMBER, b, sc.mode == LX_NUM_FIRST, LX_NUM_REST);
        end else begin
          close_run(KIND_NUMBER); start_token(b);
        end
      end
      LX_DASH: begin
        if (is_space(b) || b == CH_NUL) begin
          emit_token(KIND_DASH, CH_DASH, 1, 1, 1); advance(0);
          sc.mode = LX_IDLE; start_token(b);
        end else if (is_digit(b)) begin
          advance(0); sc.point_seen = 1'b0; sc.mode = LX_NUM_FIRST;
          extend_run(KIND_NUMBER, b, 1, LX_NUM_REST);
        end else if (is_sym_byte(CH_DASH)) begin
          // dash becomes the first symbol byte
          advance(0); sc.mode = LX_SYM_FIRST; feed_byte(b);
        end else begin
          raise_error(ERR_CHAR, sc.tok_col);
        end
      end
      LX_LIT: begin
        if (sc.la_n < 3) begin
          sc.la[sc.la_n] = b;
          sc.la_n++;
        end
        resolve_literal(0);
      end
      default: begin
        sc.mode = LX_IDLE; start_token(b);
      end
    endcase
  endfunction

  function automatic void flush_buffer();
    case (sc.mode)
      LX_CMT_EMPTY, LX_CMT_FIRST, LX_CMT_REST: close_run(KIND_COMMENT);
      LX_SYM_FIRST, LX_SYM_REST: close_run(KIND_SYMBOL);
      LX_NUM_FIRST, LX_NUM_REST: close_run(KIND_NUMBER);
      LX_DASH: begin
        emit_token(KIND_DASH, CH_DASH, 1, 1, 1); advance(0); sc.mode = LX_IDLE;
      end
      LX_LIT: resolve_literal(1);
      default: sc.mode = LX_IDLE;
    endcase
  endfunction

  // results caused by one accepted byte land in burst
  function automatic void lex_byte(logic [7:0] b, bit fin);
    res_t r;
    burst.delete();
    if (sc.halted) return;
    feed_byte(b);
    if (!sc.halted && fin) begin
      flush_buffer();
      if (!sc.halted) begin
        if (burst.size() == 0)
          push_result(KIND_END, 8'h00, 0, 0, 0, sc.cur_line, sc.cur_col, ERR_NONE, 1);
        else begin
          r = burst.pop_back();
          r.done = 1'b1;
          burst.push_back(r);
        end
        clear_scan();
      end
    end
  endfunction

  // dry run of a byte sequence: no error, and not left waiting on a literal or dash
  function automatic bit safe_sequence(src_t seq[$]);
    scan_t saved;
    bit    ok;
    saved = sc;
    ok = 1'b1;
    foreach (seq[i]) begin
      lex_byte(seq[i].b, seq[i].f);
      if (sc.halted) ok = 1'b0;
    end
    if (sc.mode == LX_LIT || sc.mode == LX_DASH) ok = 1'b0;
    sc = saved;
    burst.delete();
    return ok;
  endfunction

  // ---------------------------------------------------------------------
  // random text: mostly well-formed tokens, some noise bytes
  // ---------------------------------------------------------------------
  function automatic logic [7:0] space_byte();
    case ($urandom_range(0, 5))
      0: return CH_TAB;
      1: return CH_NL;
      2: return CH_VT;
      3: return CH_FF;
      4: return CH_CR;
      default: return CH_SPACE;
    endcase
  endfunction

  function automatic void build_token(ref src_t seq[$]);
    src_t s;
    int   n;
    s.f = 1'b0;
    seq.delete();
    case ($urandom_range(0, 10))
      0: repeat ($urandom_range(1, 3)) begin s.b = space_byte(); seq.push_back(s); end
      1: begin
        s.b = CH_HASH; seq.push_back(s);
        repeat ($urandom_range(0, 4)) begin
          s.b = 8'($urandom_range(1, 255));
          if (s.b == CH_NL) s.b = 8'h80;
          seq.push_back(s);
        end
      end
      2: repeat ($urandom_range(1, 4)) begin
        s.b = 8'($urandom_range(0, 127)); seq.push_back(s);
      end
      3: begin
        if ($urandom_range(0, 1)) begin s.b = CH_DASH; seq.push_back(s); end
        repeat ($urandom_range(1, 3)) begin
          s.b = 8'($urandom_range(CH_ZERO, CH_NINE)); seq.push_back(s);
        end
        if ($urandom_range(0, 1)) begin
          s.b = CH_DOT; seq.push_back(s);
          repeat ($urandom_range(0, 2)) begin
            s.b = 8'($urandom_range(CH_ZERO, CH_NINE)); seq.push_back(s);
          end
        end
      end
      4: begin s.b = CH_DOT; seq.push_back(s); end
      5: begin s.b = CH_DASH; seq.push_back(s); end
      6: begin s.b = CH_NUL; seq.push_back(s); end
      7: begin
        s.b = CH_QUOTE; seq.push_back(s);
        s.b = 8'($urandom_range(0, 255)); seq.push_back(s);
        s.b = CH_QUOTE; seq.push_back(s);
      end
      8: begin
        s.b = CH_QUOTE; seq.push_back(s);
        s.b = CH_BSL; seq.push_back(s);
        case ($urandom_range(0, 4))
          0: s.b = CH_N;
          1: s.b = CH_T;
          2: s.b = CH_R;
          3: s.b = CH_V;
          default: s.b = CH_F;
        endcase
        seq.push_back(s);
        s.b = CH_QUOTE; seq.push_back(s);
      end
      9: repeat ($urandom_range(1, 3)) begin
        s.b = 8'($urandom_range(0, 255)); seq.push_back(s);
      end
      default: begin
        n = $urandom_range(1, 5);
        repeat (n) begin s.b = 8'($urandom_range(8'h61, 8'h7A)); seq.push_back(s); end
      end
    endcase
    // buffer end now and then, on the token or on the separator
    if ($urandom_range(0, 15) == 0) seq[$].f = 1'b1;
    s.b = space_byte();
    s.f = ($urandom_range(0, 7) == 0);
    seq.push_back(s);
  endfunction

  // ---------------------------------------------------------------------
  // request driving
  // ---------------------------------------------------------------------
  task automatic send_byte(logic [7:0] b, bit fin, bit typed = 1'b0, res_t fixed = '0);
    if ($urandom_range(0, 99) < send_idle) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
    end
    push <= 1'b1;
    text_byte <= b;
    final_byte <= fin;
    do @(posedge clk); while (full);
    // accepted at this edge
    lex_byte(b, fin);
    if (typed) expected_tokens.push_back(fixed);
    else foreach (burst[i]) expected_tokens.push_back(burst[i]);
  endtask

  task automatic write_masks(logic [63:0] lo, logic [63:0] hi);
    @(posedge clk);
    cfg_write <= 1'b1; cfg_index <= REG_MASK_LOW; cfg_data <= lo;
    @(posedge clk);
    cfg_index <= REG_MASK_HIGH; cfg_data <= hi;
    @(posedge clk);
    cfg_write <= 1'b0;
    mask_lo = lo;
    mask_hi = hi;
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic drow_t row(logic [7:0] b, bit f);
    drow_t d;
    d.b = b; d.f = f; d.typed = 1'b0; d.fixed = '0;
    return d;
  endfunction

  function automatic drow_t trow(logic [7:0] b, bit f, res_t r);
    drow_t d;
    d.b = b; d.f = f; d.typed = 1'b1; d.fixed = r;
    return d;
  endfunction

  // ---------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    res_t got, want;
    if (!rst && pop && !empty) begin
      got.kind = token_kind; got.cbyte = content_byte; got.valid = content_valid;
      got.first = token_first; got.last = token_last; got.line = start_line;
      got.col = start_column; got.err = error_code; got.done = input_done;
      if (expected_tokens.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected token result %p", got);
      end else begin
        want = expected_tokens.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= 10)
            $display("token mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // receiver: random pop, plus one long hold-off on request
  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      pop <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // watchdog on cycles where no request moves
  int stall_cycles = 0;
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------
  initial begin : stimulus
    drow_t dir_rows[25];
    src_t  seq[$];
    src_t  tail[$];
    src_t  s;
    int    sent;
    bit    found;
    logic [63:0] lo_set[4], hi_set[4];

    mask_lo = '0;
    mask_hi = '0;
    clear_scan();
    sc.halted = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // letters, underscore, dollar and colon as symbol bytes
    write_masks(64'h0400_0010_0000_0000, 64'h07FF_FFFE_87FF_FFFE);

    // directed text: every token kind, escapes, dash cases, buffer ends
    dir_rows = '{
      trow(CH_DOT, 0, '{KIND_DOT, CH_DOT, 1, 1, 1, 16'd1, 16'd0, ERR_NONE, 0}),
      row(CH_SPACE, 0), row(CH_HASH, 0), row(8'h78, 0), row(CH_NL, 0),
      row(CH_DASH, 0), row(CH_SPACE, 0),                 // lone dash
      row(CH_DASH, 0), row(8'h35, 0), row(CH_DOT, 0),    // negative number with point
      row(CH_DOT, 0),                                    // second point closes it
      row(CH_QUOTE, 0), row(CH_BSL, 0), row(CH_T, 0), row(CH_QUOTE, 0),
      row(CH_QUOTE, 0), row(8'h71, 0), row(CH_QUOTE, 0), // plain literal
      row(8'h61, 0), row(8'h62, 0), row(CH_HASH, 0),     // symbol then empty comment
      row(CH_NUL, 1),
      trow(CH_NUL, 0, '{KIND_END, CH_NUL, 1, 1, 1, 16'd1, 16'd0, ERR_NONE, 0}),
      trow(CH_SPACE, 1, '{KIND_SPACE, 8'h00, 0, 1, 1, 16'd1, 16'd1, ERR_NONE, 1}),
      row(8'h37, 1)                                      // number flushed by buffer end
    };
    send_idle = 31;
    recv_idle = 48;
    foreach (dir_rows[i]) send_byte(dir_rows[i].b, dir_rows[i].f, dir_rows[i].typed,
                                    dir_rows[i].fixed);
    wait_drained();

    // mask settings per phase: text-like, all ones, all zero, random
    lo_set = '{64'h0400_0010_0000_0000, '1, '0, {$urandom, $urandom}};
    hi_set = '{64'h07FF_FFFE_87FF_FFFE, '1, '0, {$urandom, $urandom}};
    for (int p = 0; p < 4; p++) begin
      write_masks(lo_set[p], hi_set[p]);
      send_idle = (p == 0) ? 31 : (p == 1) ? 48 : 0;
      recv_idle = (p == 0) ? 48 : (p == 1) ? 31 : 0;
      // input keeps going while the receiver sits still, so both queues fill
      if (p == 0) hold_req = 1;
      sent = 0;
      while (sent < PHASE_BYTES) begin
        found = 0;
        for (int t = 0; t < 8 && !found; t++) begin
          build_token(seq);
          found = safe_sequence(seq);
        end
        if (!found) begin
          seq.delete();
          s.b = CH_NL; s.f = 1'b0;
          seq.push_back(s);
        end
        foreach (seq[i]) send_byte(seq[i].b, seq[i].f);
        sent += seq.size();
      end
      // close the buffer so the next mask meets a clean lexer
      send_byte(CH_NL, 1);
      wait_drained();
    end

    // one error ends the run: unknown escape, bad literal size or unknown byte
    s.f = 1'b0;
    case ($urandom_range(0, 2))
      0: begin
        s.b = CH_QUOTE; tail.push_back(s); s.b = CH_BSL; tail.push_back(s);
        s.b = 8'h7A; tail.push_back(s); s.b = CH_QUOTE; tail.push_back(s);
      end
      1: begin
        s.b = CH_QUOTE; tail.push_back(s); s.b = 8'h61; tail.push_back(s);
        s.b = 8'h62; tail.push_back(s);
      end
      default: begin
        s.b = 8'h80; tail.push_back(s);
      end
    endcase
    // swallowed after the error
    s.b = 8'h61; tail.push_back(s);
    s.b = CH_NL; s.f = 1'b1; tail.push_back(s);
    foreach (tail[i]) send_byte(tail[i].b, tail[i].f);
    wait_drained();

    if (expected_tokens.size() != 0) fail_count++;
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/att_pkg.sv
sv/att_fifo.sv
sv/att_front.sv
sv/att_lexer.sv
sv/assembly_text_tokenizer_top.sv
sv/att_checker.sv
tb/sv/tb_assembly_text_tokenizer_top.sv
